// ===== rtl/tedq_pkg.sv =====
package tedq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS         = 16;
  localparam int RES_CNT_W           = $clog2(MAX_RESULTS + 1);

  localparam int VALUE_W = 32;
  localparam int TIME_W  = 32;
  localparam int DELAY_W = 24;
  localparam int ELAP_W  = 24;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DELAY_W-1:0] DELAY_LIMIT = 24'd10000000;

  // register byte address of delay_time, bit 2 and up
  localparam logic [CFG_ADDR_W-3:0] REG_DELAY_TIME = 1'b0;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

endpackage

// ===== rtl/tedq_ram.sv =====
module tedq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/timestamped_event_delay_queue_top.sv =====
// Timestamped delay queue. A store item (tuser = 0) keeps its value with the
// current time as stamp; if the newest entry already carries that stamp its
// value is replaced, and a value for a new stamp at a full queue is dropped.
// A tick item (tuser = 1) adds elapsed microseconds to the current time
// (saturating), then releases the oldest entries whose stamp plus delay_time
// has been reached, at most 16 per tick, with tlast on the final one; an
// empty queue after the tick brings time back to zero. One shared 33-bit
// adder does both the time advance and each due-time sum, and the entry
// store is a memory with registered read, so a tick passes an advance
// step, then a check and a read step per released entry, and waits while
// the output side stalls. in_tready is low while a tick is in progress.
// The delay register (byte address 0) clamps writes above ten seconds.
module timestamped_event_delay_queue_top
  import tedq_pkg::*;
#(
  parameter int QUEUE_DEPTH = tedq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tedq_pkg::IN_DATA_W-1:0]  in_tdata,   // value_in[31:0], elapsed[55:32]
  input  logic [0:0]                      in_tuser,   // operation[0]
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tedq_pkg::OUT_DATA_W-1:0] out_tdata,  // value_out[31:0]
  output logic                            out_tlast,
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tedq_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tedq_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [tedq_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = TIME_W + VALUE_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADVANCE,
    S_CHECK,
    S_READ
  } state_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [TIME_W-1:0]    time_r, time_nxt;
  logic [TIME_W-1:0]    newest_stamp_r, newest_stamp_nxt;
  logic [DELAY_W-1:0]   delay_r, delay_nxt;
  logic [ELAP_W-1:0]    elapsed_r, elapsed_nxt;
  logic [RES_CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic [VALUE_W-1:0]   hold_val_r, hold_val_nxt;
  logic                 hold_vld_r, hold_vld_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]   out_val_r, out_val_nxt;
  logic                 out_last_r, out_last_nxt;

  // entry memory, {stamp, value}
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     ram_rdata;
  logic [TIME_W-1:0]    head_stamp;
  logic [VALUE_W-1:0]   head_value;

  // shared adder
  logic [TIME_W-1:0]    add_a;
  logic [TIME_W-1:0]    add_b;
  logic [TIME_W:0]      add_sum;

  logic                 in_acc;
  op_t                  in_op;
  logic [VALUE_W-1:0]   in_value;
  logic [ELAP_W-1:0]    in_elapsed;
  logic [IDX_W-1:0]     newest_idx;
  logic                 out_free;
  logic                 due_hit;
  logic                 cfg_wr;
  logic [DELAY_W-1:0]   cfg_delay;

  assign in_op      = op_t'(in_tuser[0]);
  assign in_value   = in_tdata[VALUE_W-1:0];
  assign in_elapsed = in_tdata[VALUE_W +: ELAP_W];
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;

  assign head_stamp = ram_rdata[VALUE_W +: TIME_W];
  assign head_value = ram_rdata[VALUE_W-1:0];

  assign newest_idx = (tail_r == '0) ? LAST_IDX : tail_r - 1'b1;
  assign out_free   = !out_valid_r || out_tready;

  // config register, clamped to ten seconds
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[CFG_ADDR_W-1:2] == REG_DELAY_TIME);
  assign cfg_delay  = cfg_pwdata[DELAY_W-1:0];
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_DELAY_TIME)
                      ? {{(CFG_DATA_W-DELAY_W){1'b0}}, delay_r} : '0;

  // one adder: time advance in the advance step, due time in the check step
  always_comb begin
    add_a = time_r;
    add_b = {{(TIME_W-ELAP_W){1'b0}}, elapsed_r};
    if (state_r == S_CHECK) begin
      add_a = head_stamp;
      add_b = {{(TIME_W-DELAY_W){1'b0}}, delay_r};
    end
  end
  assign add_sum = {1'b0, add_a} + {1'b0, add_b};

  assign due_hit = (count_r != '0) && (res_cnt_r != RES_CNT_W'(MAX_RESULTS))
                   && (add_sum <= {1'b0, time_r});

  always_comb begin
    state_nxt        = state_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    count_nxt        = count_r;
    time_nxt         = time_r;
    newest_stamp_nxt = newest_stamp_r;
    delay_nxt        = delay_r;
    elapsed_nxt      = elapsed_r;
    res_cnt_nxt      = res_cnt_r;
    hold_val_nxt     = hold_val_r;
    hold_vld_nxt     = hold_vld_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_val_nxt      = out_val_r;
    out_last_nxt     = out_last_r;
    ram_we           = 1'b0;
    ram_waddr        = tail_r;
    ram_wdata        = {time_r, in_value};

    if (cfg_wr) begin
      delay_nxt = (cfg_delay > DELAY_LIMIT) ? DELAY_LIMIT : cfg_delay;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_TICK) begin
            elapsed_nxt = in_elapsed;
            state_nxt   = S_ADVANCE;
          end else if (count_r != '0 && newest_stamp_r == time_r) begin
            // same time step: overwrite the newest entry
            ram_we    = 1'b1;
            ram_waddr = newest_idx;
          end else if (count_r != FULL_CNT) begin
            ram_we           = 1'b1;
            ram_waddr        = tail_r;
            tail_nxt         = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
            count_nxt        = count_r + 1'b1;
            newest_stamp_nxt = time_r;
          end
        end
      end
      S_ADVANCE: begin
        time_nxt    = add_sum[TIME_W] ? '1 : add_sum[TIME_W-1:0];
        res_cnt_nxt = '0;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        // one entry is held back so the final release can carry tlast
        if (!hold_vld_r || out_free) begin
          if (hold_vld_r) begin
            out_valid_nxt = 1'b1;
            out_val_nxt   = hold_val_r;
            out_last_nxt  = !due_hit;
          end
          if (due_hit) begin
            hold_val_nxt = head_value;
            hold_vld_nxt = 1'b1;
            head_nxt     = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
            count_nxt    = count_r - 1'b1;
            res_cnt_nxt  = res_cnt_r + 1'b1;
            state_nxt    = S_READ;
          end else begin
            hold_vld_nxt = 1'b0;
            if (count_r == '0) begin
              time_nxt = '0;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      S_READ: begin
        // memory read of the new head lands for the next check
        state_nxt = S_CHECK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      time_r      <= '0;
      delay_r     <= '0;
      res_cnt_r   <= '0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      time_r      <= time_nxt;
      delay_r     <= delay_nxt;
      res_cnt_r   <= res_cnt_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    newest_stamp_r <= newest_stamp_nxt;
    elapsed_r      <= elapsed_nxt;
    hold_val_r     <= hold_val_nxt;
    out_val_r      <= out_val_nxt;
    out_last_r     <= out_last_nxt;
  end

  tedq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/tedq_checker.sv =====
module tedq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [0:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tedq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import tedq_pkg::*;

  // reset leaves no result pending
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result item valid right after reset");

  // a tick keeps the input side closed for at least its time advance
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] == OP_TICK) |=> !in_tready)
    else $error("input ready right after a tick item");

  // a store item never leads to a result without an earlier pending one
  a_store_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] == OP_STORE && !out_tvalid) |=> !out_tvalid)
    else $error("result item appeared after a store item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result item changed");

endmodule

bind timestamped_event_delay_queue_top tedq_checker u_tedq_checker (.*);

// ===== tb/sv/delay_queue_checker.sv =====
`timescale 1ns / 100ps

module delay_queue_checker
  import tedq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // value_in[31:0], elapsed[55:32]
  input  logic [0:0]            in_tuser,   // operation[0]
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // value_out[31:0]
  input  logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  output int                    mismatch_count,
  output int                    values_pending,
  output int                    values_checked
);

  localparam int DEPTH     = DEFAULT_QUEUE_DEPTH;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } release_t;

  // shadow of the queue and its clock
  logic [TIME_W-1:0]  stamp_mem [DEPTH];
  logic [VALUE_W-1:0] value_mem [DEPTH];
  int unsigned        oldest;
  int unsigned        next_free;
  int unsigned        fill;
  logic [TIME_W-1:0]  now_us;
  logic [DELAY_W-1:0] delay_us;
  release_t           due_values [$];

  release_t           want;
  logic [DELAY_W-1:0] wr_delay;

  initial begin
    mismatch_count = 0;
    values_pending = 0;
    values_checked = 0;
  end

  function automatic void flag(input string msg);
    if (mismatch_count < MAX_SHOWN) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    mismatch_count++;
  endfunction

  // one value per stamp: a second value at the same stamp replaces the newest
  function automatic void predict_store(input logic [VALUE_W-1:0] v);
    int unsigned newest;
    newest = (next_free + DEPTH - 1) % DEPTH;
    if (fill > 0 && stamp_mem[newest] == now_us) begin
      value_mem[newest] = v;
    end else if (fill < DEPTH) begin
      stamp_mem[next_free] = now_us;
      value_mem[next_free] = v;
      next_free = (next_free + 1) % DEPTH;
      fill++;
    end
  endfunction

  function automatic void predict_tick(input logic [ELAP_W-1:0] el);
    logic [TIME_W:0] sum;
    release_t        r;
    int              n;
    sum    = {1'b0, now_us} + el;
    now_us = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    n      = 0;
    while (fill > 0 && n < MAX_RESULTS) begin
      sum = {1'b0, stamp_mem[oldest]} + delay_us;
      if (sum > {1'b0, now_us}) break;
      r.value = value_mem[oldest];
      r.last  = 1'b0;
      due_values.push_back(r);
      oldest = (oldest + 1) % DEPTH;
      fill--;
      n++;
    end
    if (n > 0) begin
      r      = due_values[due_values.size() - 1];
      r.last = 1'b1;
      due_values[due_values.size() - 1] = r;
    end
    if (fill == 0) now_us = '0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      oldest    = 0;
      next_free = 0;
      fill      = 0;
      now_us    = '0;
      delay_us  = '0;
      due_values.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        values_checked++;
        if (due_values.size() == 0) begin
          flag($sformatf("value %h last %b released with nothing due", out_tdata, out_tlast));
        end else begin
          want = due_values.pop_front();
          if (out_tdata !== want.value) begin
            flag($sformatf("value_out: expected %h, got %h", want.value, out_tdata));
          end
          if (out_tlast !== want.last) begin
            flag($sformatf("last on value %h: expected %b, got %b",
                           want.value, want.last, out_tlast));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == OP_TICK) begin
          predict_tick(in_tdata[VALUE_W +: ELAP_W]);
        end else begin
          predict_store(in_tdata[VALUE_W-1:0]);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == REG_DELAY_TIME) begin
        if (cfg_pwrite) begin
          wr_delay = cfg_pwdata[DELAY_W-1:0];
          delay_us = (wr_delay > DELAY_LIMIT) ? DELAY_LIMIT : wr_delay;
        end else if (cfg_prdata !== {{(CFG_DATA_W-DELAY_W){1'b0}}, delay_us}) begin
          flag($sformatf("delay_time read: expected %h, got %h", delay_us, cfg_prdata));
        end
      end
    end
    values_pending = due_values.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import tedq_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;  // long receiver hold-off
  localparam int TAIL_CYCLES = 16;   // covers a tick that releases nothing

  // register byte addresses
  localparam logic [CFG_ADDR_W-1:0] ADDR_DELAY = {REG_DELAY_TIME, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = ADDR_DELAY + 3'd4;  // nothing mapped here

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;     // value_in[31:0], elapsed[55:32]
  logic [0:0]            in_tuser = '0;     // operation[0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // value_out[31:0]
  logic                  out_tlast;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int mismatch_count;
  int values_pending;
  int values_checked;

  // stimulus bookkeeping
  int                 items_sent = 0;
  int                 ticks_sent = 0;
  logic [DELAY_W-1:0] delay_now = '0;   // delay the block should be using
  logic               idle_on = 1'b1;   // random gaps on both sides
  int                 hold_requests = 0;
  int                 holds_served = 0;
  int                 hold_left = 0;
  int                 cycle_count = 0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  timestamped_event_delay_queue_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  delay_queue_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (mismatch_count),
    .values_pending (values_pending),
    .values_checked (values_checked)
  );

  // receiver: random back-pressure, plus a long hold-off whenever the
  // stimulus asks for one; the hold is counted here, not in the sender
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= !(idle_on && $urandom_range(99) < 18);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d values still due", cycle_count, values_pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // value words lean on the all-zeros and all-ones corners now and then
  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // elapsed time scaled to the delay so that ticks release now and then
  function automatic logic [ELAP_W-1:0] rand_elapsed(input logic [DELAY_W-1:0] d);
    int unsigned pick;
    int unsigned hi;
    pick = $urandom_range(99);
    hi   = 2 * 32'(d) + 2;
    if (hi > 32'(DELAY_LIMIT)) hi = 32'(DELAY_LIMIT);
    if (pick < 10) return '0;
    if (pick < 55) return ELAP_W'($urandom_range(1, 32'(d) / 3 + 1));
    if (pick < 65) return d;
    if (pick < 90) return ELAP_W'($urandom_range(0, hi));
    return ELAP_W'($urandom_range(0, 32'(DELAY_LIMIT)));
  endfunction

  // one item on the input side; optional gap first, then wait for the handshake
  task automatic push_item(input op_t op, input logic [VALUE_W-1:0] v,
                           input logic [ELAP_W-1:0] el);
    int gap;
    gap = 0;
    if (idle_on) begin
      while ($urandom_range(99) < 18) gap++;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {el, v};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (op == OP_TICK) ticks_sent++;
  endtask

  // setup cycle, access cycle, then the bus is released
  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering items and wait until every due value has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (values_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // new delay only while the block is quiet; read it back for the checker
  task automatic set_delay(input logic [CFG_DATA_W-1:0] wdata);
    logic [DELAY_W-1:0] w;
    settle();
    cfg_access(1'b1, ADDR_DELAY, wdata);
    cfg_access(1'b0, ADDR_DELAY, '0);
    w         = wdata[DELAY_W-1:0];
    delay_now = (w > DELAY_LIMIT) ? DELAY_LIMIT : w;
  endtask

  // zero delay and one tick: everything goes out and the clock restarts at zero
  task automatic empty_queue();
    set_delay('0);
    push_item(OP_TICK, $urandom, '0);
  endtask

  // random phase: mostly store/tick runs with random content, some queue
  // fills that end in a big flush, and a little raw noise
  task automatic run_phase(input logic [CFG_DATA_W-1:0] wdata, input int n_items,
                           input bit quiet, input bit squeeze);
    int                first;
    int                n;
    int unsigned       pick;
    bit                squeezed;
    logic [ELAP_W-1:0] flush;
    idle_on <= !quiet;
    set_delay(wdata);
    first    = items_sent;
    squeezed = 1'b0;
    while (items_sent - first < n_items) begin
      pick = $urandom_range(99);
      if (squeeze && !squeezed && items_sent - first >= 6) begin
        // receiver goes deaf while a queue fill and its flush arrive
        hold_requests <= hold_requests + 1;
        squeezed = 1'b1;
        pick     = 0;
      end
      if (pick < 25 && delay_now >= 20) begin
        // fill up to or past the depth with one-microsecond steps, overwrite the
        // newest stamp now and then, then release everything at once
        n = $urandom_range(12, 20);
        repeat (n) begin
          push_item(OP_STORE, rand_value(), ELAP_W'($urandom));
          if ($urandom_range(3) == 0) push_item(OP_STORE, rand_value(), ELAP_W'($urandom));
          push_item(OP_TICK, $urandom, 24'd1);
        end
        flush = (delay_now > DELAY_LIMIT - 24'd64) ? DELAY_LIMIT : delay_now + 24'd64;
        push_item(OP_TICK, $urandom, flush);
      end else if (pick < 85) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          push_item(OP_STORE, rand_value(), ELAP_W'($urandom));
          if ($urandom_range(4) == 0) push_item(OP_STORE, rand_value(), ELAP_W'($urandom));
          push_item(OP_TICK, $urandom, rand_elapsed(delay_now));
        end
      end else begin
        push_item(op_t'($urandom_range(1)), rand_value(),
                  ELAP_W'($urandom_range(0, 32'(DELAY_LIMIT))));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // delay is zero out of reset: a value is due on the tick that follows it
    push_item(OP_TICK, $urandom, '0);                // tick with nothing stored
    push_item(OP_STORE, 32'h0000_0000, ELAP_W'($urandom));
    push_item(OP_STORE, 32'hFFFF_FFFF, ELAP_W'($urandom));  // same stamp, replaces the zero
    push_item(OP_TICK, $urandom, '0);
    push_item(OP_STORE, 32'hA5A5_5A5A, ELAP_W'($urandom));
    push_item(OP_TICK, $urandom, DELAY_LIMIT);       // elapsed at the ten second limit

    // bits above the 24-bit register are dropped, leaving 100 us
    set_delay(32'hFF00_0064);
    cfg_access(1'b1, ADDR_SPARE, $urandom);
    push_item(OP_STORE, 32'h0000_0001, ELAP_W'($urandom));  // stamp 0
    push_item(OP_TICK, $urandom, 24'd60);
    push_item(OP_STORE, 32'h0000_0002, ELAP_W'($urandom));  // stamp 60
    push_item(OP_TICK, $urandom, 24'd40);            // first one due exactly now
    push_item(OP_STORE, 32'h0000_0003, ELAP_W'($urandom));  // stamp 100
    push_item(OP_TICK, $urandom, '0);
    push_item(OP_TICK, $urandom, 24'd59);            // one short of due
    push_item(OP_TICK, $urandom, 24'd1);
    push_item(OP_TICK, $urandom, 24'd40);            // queue empties, clock back to zero

    // above the limit: acts as ten seconds
    set_delay(32'h00FF_FFFF);
    push_item(OP_STORE, 32'h8000_0000, ELAP_W'($urandom));
    push_item(OP_TICK, $urandom, 24'd9999999);
    push_item(OP_STORE, 32'h7FFF_FFFF, ELAP_W'($urandom));
    push_item(OP_TICK, $urandom, 24'd1);
    push_item(OP_TICK, $urandom, DELAY_LIMIT);

    // random phases over a spread of delays; one with no gaps at all, one
    // with the long receiver hold-off
    run_phase(32'h0000_0000, 50, 1'b0, 1'b0);
    run_phase(32'h0000_0025, 50, 1'b1, 1'b0);
    run_phase(32'h0000_1388, 55, 1'b0, 1'b1);
    run_phase(32'h0000_0001, 40, 1'b0, 1'b0);
    run_phase({8'h00, DELAY_LIMIT}, 50, 1'b0, 1'b0);
    run_phase({8'($urandom_range(0, 255)), 24'h0}
              | 32'($urandom_range(2, 200)), 50, 1'b0, 1'b0);

    empty_queue();
    settle();

    $display("covered %0d items (%0d ticks), delays 0 to the ten second limit, full-queue",
             items_sent, ticks_sent);
    $display("flushes and a %0d-cycle output stall; %0d values checked",
             HOLD_CYCLES, values_checked);
    if (mismatch_count == 0 && values_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d values never released", mismatch_count, values_pending);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
